>>> rtl/swdb_pkg.sv
// Shared types and constants for the switch debouncer with edge verification.
// Used by swdb_regs, swdb_core and the top level; depends on nothing.
`default_nettype none

package swdb_pkg;

  localparam int unsigned DEBOUNCE_W     = 16;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned IN_TDATA_W     = 40;
  localparam int unsigned OUT_TDATA_W    = 8;
  localparam int unsigned PADDR_W        = 3;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

  // Register index, taken from paddr[2].
  localparam logic REG_DEBOUNCE = 1'b0;

  typedef struct packed {
    logic              consume_rejected;
    logic              consume_released;
    logic              consume_pressed;
    logic              edge_notify;
    logic [TIME_W-1:0] now_ms;
    logic              raw_level;
  } item_t;

  typedef struct packed {
    logic verify_pending;
    logic rejected_event;
    logic released_event;
    logic pressed_event;
    logic stable_pressed;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/switch_debouncer_with_edge_verify.sv
// Top level of the switch debouncer with edge verification: stream ports,
// input and result registers. Depends on swdb_pkg, swdb_regs and swdb_core.
//
// Usage: each transfer on the s_axis side is one update of the switch: the
// raw level, the millisecond timestamp, a latched rising-edge notification
// and three consume requests for the sticky event flags. Each update gives
// exactly one result transfer on the m_axis side with the debounced level,
// the pressed, released and rejected flags (as they stood before consume)
// and whether an edge is under verification.
// The update passes through the input register, where the update is computed
// and the state written, then the result register, from which it transfers.
// Throughput is one item per cycle while the receiver keeps taking results,
// since the state is updated from the input register.
// The debounce time is written through the APB-style port at address 0
// and should only change while no update is in flight.
// Reset clears the debounce state, empties both registers and sets the
// debounce time to 50 ms. When the receiver holds m_tready low, the result
// waits in its register; one more item is still taken into the input
// register, and s_tready then drops until the result is taken.
`default_nettype none

module switch_debouncer_with_edge_verify (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // raw_level[0], now_ms[32:1], edge_notify[33], consume_pressed[34],
  // consume_released[35], consume_rejected[36], zero[39:37]
  input  wire logic [swdb_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // stable_pressed[0], pressed_event[1], released_event[2],
  // rejected_event[3], verify_pending[4], zero[7:5]
  output logic      [swdb_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [swdb_pkg::PADDR_W-1:0]         paddr,
  input  wire logic [31:0]                          pwdata,
  output logic      [31:0]                          prdata,
  output logic                                      pready
);

  localparam int unsigned ITEM_W   = $bits(swdb_pkg::item_t);
  localparam int unsigned RESULT_W = $bits(swdb_pkg::result_t);

  logic                                 in_valid;
  swdb_pkg::item_t                      in_item;
  logic                                 step;
  logic [swdb_pkg::DEBOUNCE_W-1:0]      debounce_ms;
  swdb_pkg::result_t                    result;
  swdb_pkg::result_t                    out_result;

  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;
  assign m_tdata  = {{(swdb_pkg::OUT_TDATA_W - RESULT_W){1'b0}}, out_result};

  swdb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .debounce_ms (debounce_ms)
  );

  swdb_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (in_item),
    .debounce_ms (debounce_ms),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (step) begin
        in_valid <= 1'b0;
      end
      if (step) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= swdb_pkg::item_t'(s_tdata[ITEM_W-1:0]);
    end
    if (step) begin
      out_result <= result;
    end
  end

endmodule

`default_nettype wire

>>> rtl/swdb_regs.sv
// APB-style configuration register holding the debounce time.
// Depends on swdb_pkg for widths, the register index and the reset value.
`default_nettype none

module swdb_regs (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [swdb_pkg::PADDR_W-1:0]          paddr,
  input  wire logic [31:0]                           pwdata,
  output logic      [31:0]                           prdata,
  output logic                                       pready,
  output logic      [swdb_pkg::DEBOUNCE_W-1:0]       debounce_ms
);

  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == swdb_pkg::REG_DEBOUNCE);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= swdb_pkg::DEBOUNCE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      debounce_ms <= pwdata[swdb_pkg::DEBOUNCE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(32 - swdb_pkg::DEBOUNCE_W){1'b0}}, debounce_ms};
    end
  end

endmodule

`default_nettype wire

>>> rtl/swdb_core.sv
// Debounce state and the single-pass update for one sample.
// Depends on swdb_pkg for the item and result structs.
`default_nettype none

module swdb_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             step,
  input  wire swdb_pkg::item_t                  item,
  input  wire logic [swdb_pkg::DEBOUNCE_W-1:0]  debounce_ms,
  output swdb_pkg::result_t                     result
);

  logic                        stable_level;
  logic                        previous_raw;
  logic [swdb_pkg::TIME_W-1:0] window_start_ms;
  logic                        verifying;
  logic                        press_flag;
  logic                        release_flag;
  logic                        reject_flag;

  logic [swdb_pkg::TIME_W-1:0] start_v;
  logic [swdb_pkg::TIME_W-1:0] start_next;
  logic [swdb_pkg::TIME_W-1:0] elapsed;
  logic                        verify_v;
  logic                        window_done;
  logic                        window_close;
  logic                        accept_press;
  logic                        stable_v;
  logic                        press_v;
  logic                        reject_v;
  logic                        prev_v;
  logic                        raw_changed;
  logic                        poll_done;
  logic                        poll_update;
  logic                        stable_next;
  logic                        press_next;
  logic                        release_next;
  logic                        verifying_next;

  // A notified edge never stays pending past the update that sees it, so
  // it opens the window directly.
  always_comb begin
    start_v      = item.edge_notify ? item.now_ms : window_start_ms;
    verify_v     = verifying | item.edge_notify;
    elapsed      = item.now_ms - start_v;
    window_done  = (elapsed >= {{(swdb_pkg::TIME_W - swdb_pkg::DEBOUNCE_W){1'b0}}, debounce_ms});
    window_close = verify_v && window_done;

    accept_press = window_close && item.raw_level && !stable_level;
    stable_v     = stable_level | accept_press;
    press_v      = press_flag | accept_press;
    reject_v     = reject_flag | (window_close && !item.raw_level);
    prev_v       = previous_raw | accept_press;

    // A level change restarts the shared timer, so the window only counts
    // as done at once when the debounce time is zero.
    raw_changed  = (item.raw_level != prev_v);
    start_next   = raw_changed ? item.now_ms : start_v;
    poll_done    = raw_changed ? (debounce_ms == '0) : window_done;
    poll_update  = poll_done && (item.raw_level != stable_v);

    stable_next    = poll_update ? item.raw_level : stable_v;
    press_next     = press_v | (poll_update && item.raw_level);
    release_next   = release_flag | (poll_update && !item.raw_level);
    verifying_next = verify_v && !window_close;

    result.stable_pressed = stable_next;
    result.pressed_event  = press_next;
    result.released_event = release_next;
    result.rejected_event = reject_v;
    result.verify_pending = verifying_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level    <= 1'b0;
      previous_raw    <= 1'b0;
      window_start_ms <= '0;
      verifying       <= 1'b0;
      press_flag      <= 1'b0;
      release_flag    <= 1'b0;
      reject_flag     <= 1'b0;
    end else if (step) begin
      stable_level    <= stable_next;
      previous_raw    <= item.raw_level;
      window_start_ms <= start_next;
      verifying       <= verifying_next;
      press_flag      <= press_next && !item.consume_pressed;
      release_flag    <= release_next && !item.consume_released;
      reject_flag     <= reject_v && !item.consume_rejected;
    end
  end

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for switch_debouncer_with_edge_verify: a directed table, then
// random update streams under several debounce times with idling on both stream sides.
// Depends on swdb_pkg and the RTL of the block.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [swdb_pkg::PADDR_W-1:0] ADDR_DEBOUNCE = {swdb_pkg::REG_DEBOUNCE, 2'b00};

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [swdb_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [swdb_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [swdb_pkg::PADDR_W-1:0]     paddr = '0;
  logic [31:0]                      pwdata = '0;
  logic [31:0]                      prdata;
  logic                             pready;

  switch_debouncer_with_edge_verify DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Debouncer state as the testbench sees it.
  logic [15:0] db_cfg = swdb_pkg::DEBOUNCE_RESET;
  logic        stable_q = 1'b0;
  logic        prev_raw = 1'b0;
  logic        edge_pend = 1'b0;
  logic        verifying_q = 1'b0;
  logic        press_q = 1'b0;
  logic        release_q = 1'b0;
  logic        reject_q = 1'b0;
  logic [31:0] win_start = '0;

  swdb_pkg::result_t expected_results[$];
  int      errors = 0;
  int      cycles = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;

  // Directed rows: debounce time, raw, now, notify, consume p/r/j, typed check, result.
  typedef struct {
    logic [15:0] db;
    bit          raw;
    logic [31:0] now;
    bit          notify;
    bit          cp;
    bit          cr;
    bit          cj;
    bit          chk;
    logic [4:0]  res;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{16'd50, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 5'b00000},
    '{16'd50, 1'b1, 32'd10,         1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 5'b00000},
    '{16'd50, 1'b1, 32'd60,         1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 5'b00011},
    '{16'd50, 1'b1, 32'd61,         1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 5'b00001},
    '{16'd50, 1'b0, 32'd70,         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b0, 32'd120,        1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b1, 32'd200,        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b1, 32'd230,        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b1, 32'd250,        1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b0, 32'd300,        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b0, 32'd360,        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b0, 32'd361,        1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 5'b00000},
    '{16'd50, 1'b0, 32'd362,        1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 5'b00000},
    '{16'd50, 1'b1, 32'd400,        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b1, 32'd420,        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b1, 32'd460,        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b1, 32'd470,        1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b0, 32'hFFFF_FFF0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b0, 32'h0000_0030,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b1, 32'hFFFF_FFFF,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b1, 32'd0,          1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b1, 32'h7FFF_FFFF,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd50, 1'b0, 32'h8000_0000,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 5'b00000},
    '{16'd0,  1'b1, 32'd1000,       1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{16'd0,  1'b0, 32'd1001,       1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 5'b00000}
  };

  function automatic bit window_done(logic [31:0] now);
    return (now - win_start) >= {16'd0, db_cfg};
  endfunction

  // One switch update; the flags are reported before the consume bits clear them.
  function automatic swdb_pkg::result_t debounce_update(swdb_pkg::item_t it);
    swdb_pkg::result_t r;
    if (it.edge_notify) edge_pend = 1'b1;
    if (edge_pend) begin
      edge_pend = 1'b0;
      verifying_q = 1'b1;
      win_start = it.now_ms;
    end
    if (verifying_q && window_done(it.now_ms)) begin
      if (it.raw_level) begin
        if (!stable_q) begin
          stable_q = 1'b1;
          press_q = 1'b1;
          prev_raw = 1'b1;
        end
      end else begin
        reject_q = 1'b1;
      end
      verifying_q = 1'b0;
    end
    if (it.raw_level != prev_raw) win_start = it.now_ms;
    if (window_done(it.now_ms) && it.raw_level != stable_q) begin
      stable_q = it.raw_level;
      if (it.raw_level) press_q = 1'b1;
      else release_q = 1'b1;
    end
    prev_raw = it.raw_level;
    r.stable_pressed = stable_q;
    r.pressed_event = press_q;
    r.released_event = release_q;
    r.rejected_event = reject_q;
    r.verify_pending = edge_pend | verifying_q;
    if (it.consume_pressed) press_q = 1'b0;
    if (it.consume_released) release_q = 1'b0;
    if (it.consume_rejected) reject_q = 1'b0;
    return r;
  endfunction

  task automatic check_field(string name, logic want, logic got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected %0b, got %0b", $time, name, want, got);
    end
  endtask

  // Offers one update, waits for its transfer and records what it must produce.
  task automatic send_update(swdb_pkg::item_t it, bit fixed, swdb_pkg::result_t fixed_res);
    swdb_pkg::result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = swdb_pkg::IN_TDATA_W'(it);
    do @(posedge clk); while (!s_tready);
    r = debounce_update(it);
    expected_results.push_back(fixed ? fixed_res : r);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_debounce(logic [15:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_DEBOUNCE;
    pwdata = {16'd0, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    db_cfg = val;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random idling, plus one long hold-off counted here.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 90;
    end
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else begin
      m_tready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    swdb_pkg::result_t want;
    swdb_pkg::result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = swdb_pkg::result_t'(m_tdata[4:0]);
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t ns: result %b with none expected", $time, m_tdata);
      end else begin
        want = expected_results.pop_front();
        check_field("stable_pressed", want.stable_pressed, got.stable_pressed);
        check_field("pressed_event", want.pressed_event, got.pressed_event);
        check_field("released_event", want.released_event, got.released_event);
        check_field("rejected_event", want.rejected_event, got.rejected_event);
        check_field("verify_pending", want.verify_pending, got.verify_pending);
      end
    end
  end

  initial begin
    swdb_pkg::item_t it;
    logic [15:0]     db_list[6];
    bit              level;
    int unsigned     span;
    int unsigned     delta;
    logic [31:0]     cur_ms;

    level = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    tx_idle_pct = 26;
    rx_idle_pct = 47;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].db != db_cfg) begin
        drain();
        write_debounce(dir_rows[i].db);
      end
      it.raw_level = dir_rows[i].raw;
      it.now_ms = dir_rows[i].now;
      it.edge_notify = dir_rows[i].notify;
      it.consume_pressed = dir_rows[i].cp;
      it.consume_released = dir_rows[i].cr;
      it.consume_rejected = dir_rows[i].cj;
      send_update(it, dir_rows[i].chk, swdb_pkg::result_t'(dir_rows[i].res));
    end
    drain();

    db_list = '{16'd0, 16'hFFFF, 16'd1, 16'd12, 16'($urandom_range(2, 400)),
                swdb_pkg::DEBOUNCE_RESET};
    for (int p = 0; p < 6; p++) begin
      tx_idle_pct = (p < 2) ? 26 : (p < 4) ? 47 : 0;
      rx_idle_pct = (p < 2) ? 47 : (p < 4) ? 26 : 0;
      write_debounce(db_list[p]);
      span = db_cfg + 2;
      // Start each run close enough to the top that the timestamp can wrap.
      cur_ms = 32'hFFFF_FFFF - $urandom_range(10, 40) * span;
      if (p == 4) hold_req = 1'b1;
      repeat (75) begin
        if ($urandom_range(9) == 0) begin
          it.now_ms = $urandom();
          it.raw_level = 1'($urandom_range(1));
          it.edge_notify = 1'($urandom_range(1));
        end else begin
          case ($urandom_range(9))
            0: delta = 0;
            1, 2: delta = span - $urandom_range(1, 3);
            default: delta = $urandom_range(span / 4 + 1);
          endcase
          cur_ms += delta;
          if ($urandom_range(4) == 0) level = ~level;
          it.now_ms = cur_ms;
          it.raw_level = level;
          it.edge_notify = (level && $urandom_range(3) == 0) || $urandom_range(9) == 0;
        end
        it.consume_pressed = ($urandom_range(2) == 0);
        it.consume_released = ($urandom_range(2) == 0);
        it.consume_rejected = ($urandom_range(2) == 0);
        send_update(it, 1'b0, '0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
